FILE: rtl/core/lsfg_pkg.sv
// Shared types, constants and frequency-table helpers for the load-step governor.
package lsfg_pkg;

  localparam int unsigned LOAD_W = 7;
  localparam int unsigned FREQ_W = 22;
  localparam int unsigned MULT_W = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 22;

  // Register reset values
  localparam logic [LOAD_W-1:0] RAISE_PCT_RST = LOAD_W'(95);
  localparam logic              BOOST_RST = 1'b0;
  localparam logic [MULT_W-1:0] SDF_RST = MULT_W'(50);
  localparam logic [FREQ_W-1:0] BIG_LIMIT_RST = FREQ_W'(2808000);
  localparam logic [MULT_W-1:0] MULT_ONE_VAL = MULT_W'(1);

  // Down threshold is up*832000/1053000 - 25. load < that holds exactly when
  // (load + 26) * 81 <= up * 64, since 832000/1053000 reduces to 64/81.
  localparam int unsigned RATIO_NUM = 832000;
  localparam int unsigned RATIO_DEN = 1053000;
  localparam int unsigned RATIO_GCD = 13000;
  localparam int unsigned RATIO_NUM_RED = RATIO_NUM / RATIO_GCD;
  localparam int unsigned RATIO_DEN_RED = RATIO_DEN / RATIO_GCD;
  localparam int unsigned DOWN_MARGIN = 25;
  localparam int unsigned DOWN_CMP_W = 14;

  localparam int unsigned LITTLE_N = 8;
  localparam int unsigned BIG_N = 12;

  localparam logic [FREQ_W-1:0] LITTLE_TAB [LITTLE_N] = '{
    FREQ_W'(832000),  FREQ_W'(1053000), FREQ_W'(1248000), FREQ_W'(1456000),
    FREQ_W'(1690000), FREQ_W'(1794000), FREQ_W'(1898000), FREQ_W'(2002000)
  };

  localparam logic [FREQ_W-1:0] BIG_TAB [BIG_N] = '{
    FREQ_W'(741000),  FREQ_W'(962000),  FREQ_W'(1170000), FREQ_W'(1469000),
    FREQ_W'(1703000), FREQ_W'(1937000), FREQ_W'(2158000), FREQ_W'(2314000),
    FREQ_W'(2496000), FREQ_W'(2652000), FREQ_W'(2704000), FREQ_W'(2808000)
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAISE_PCT = 2'd0,
    CFG_BOOST     = 2'd1,
    CFG_SDF       = 2'd2,
    CFG_BIG_LIMIT = 2'd3
  } lsfg_cfg_idx_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_RAISE = 2'd1,
    ACT_LOWER = 2'd2
  } lsfg_action_e;

  typedef enum logic [1:0] {
    MULT_KEEP = 2'd0,
    MULT_LOAD = 2'd1,
    MULT_ONE  = 2'd2
  } lsfg_mult_op_e;

  typedef struct packed {
    logic [LOAD_W-1:0] raise_pct;
    logic              boost;
    logic [MULT_W-1:0] hold_factor;
    logic [FREQ_W-1:0] big_cluster_limit;
  } lsfg_cfg_t;

  typedef struct packed {
    lsfg_action_e      action;
    logic [FREQ_W-1:0] target;
    lsfg_mult_op_e     mult_op;
  } lsfg_dec_t;

  // Next table entry up; the top two entries and misses give the fallback.
  function automatic logic [FREQ_W-1:0] step_up(input logic cl,
                                                input logic [FREQ_W-1:0] cur,
                                                input logic [FREQ_W-1:0] fallback);
    logic [FREQ_W-1:0] res;
    res = fallback;
    if (cl) begin
      for (int i = 0; i < BIG_N - 2; i++) begin
        if (cur == BIG_TAB[i]) res = BIG_TAB[i+1];
      end
    end else begin
      for (int i = 0; i < LITTLE_N - 2; i++) begin
        if (cur == LITTLE_TAB[i]) res = LITTLE_TAB[i+1];
      end
    end
    return res;
  endfunction

  // Next table entry down; the bottom two entries and misses give the fallback.
  function automatic logic [FREQ_W-1:0] step_down(input logic cl,
                                                  input logic [FREQ_W-1:0] cur,
                                                  input logic [FREQ_W-1:0] fallback);
    logic [FREQ_W-1:0] res;
    res = fallback;
    if (cl) begin
      for (int i = 2; i < BIG_N; i++) begin
        if (cur == BIG_TAB[i]) res = BIG_TAB[i-1];
      end
    end else begin
      for (int i = 2; i < LITTLE_N; i++) begin
        if (cur == LITTLE_TAB[i]) res = LITTLE_TAB[i-1];
      end
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/lsfg_cfg_regs.sv
// Configuration register file of the load-step governor.
module lsfg_cfg_regs import lsfg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output lsfg_cfg_t             cfg_o
);

  lsfg_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (lsfg_cfg_idx_e'(cfg_idx_i))
        CFG_RAISE_PCT: cfg_d.raise_pct = cfg_wdata_i[LOAD_W-1:0];
        CFG_BOOST:     cfg_d.boost = cfg_wdata_i[0];
        CFG_SDF:       cfg_d.hold_factor = cfg_wdata_i[MULT_W-1:0];
        CFG_BIG_LIMIT: cfg_d.big_cluster_limit = cfg_wdata_i[FREQ_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.raise_pct         <= RAISE_PCT_RST;
      cfg_q.boost             <= BOOST_RST;
      cfg_q.hold_factor       <= SDF_RST;
      cfg_q.big_cluster_limit <= BIG_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/lsfg_decide.sv
// Per-sample raise/lower decision and multiplier update selection.
module lsfg_decide import lsfg_pkg::*; (
  input  lsfg_cfg_t         cfg_i,
  input  logic              cluster_i,
  input  logic [LOAD_W-1:0] load_i,
  input  logic [FREQ_W-1:0] current_freq_i,
  input  logic [FREQ_W-1:0] freq_min_i,
  input  logic [FREQ_W-1:0] freq_max_i,
  output lsfg_dec_t         dec_o
);

  logic                  high_load;
  logic                  at_top;
  logic [FREQ_W-1:0]     up_step;
  logic [FREQ_W-1:0]     up_req;
  logic [FREQ_W-1:0]     dn_step;
  logic [FREQ_W-1:0]     dn_req;
  logic [DOWN_CMP_W-1:0] down_lhs;
  logic [DOWN_CMP_W-1:0] down_rhs;
  logic                  below_down;

  assign high_load = (load_i >= cfg_i.raise_pct);
  assign at_top    = (current_freq_i == freq_max_i) ||
                     (cluster_i && (current_freq_i == cfg_i.big_cluster_limit));

  assign up_step = step_up(cluster_i, current_freq_i, freq_max_i);
  always_comb begin
    if (cfg_i.boost || (up_step > freq_max_i)) up_req = freq_max_i;
    else                                       up_req = up_step;
  end

  assign dn_step = step_down(cluster_i, current_freq_i, freq_min_i);
  assign dn_req  = (dn_step < freq_min_i) ? freq_min_i : dn_step;

  // load < up*64/81 - 25, division free
  assign down_lhs = (DOWN_CMP_W'(load_i) + DOWN_CMP_W'(DOWN_MARGIN + 1)) *
                    DOWN_CMP_W'(RATIO_DEN_RED);
  assign down_rhs = DOWN_CMP_W'(cfg_i.raise_pct) * DOWN_CMP_W'(RATIO_NUM_RED);
  assign below_down = (down_lhs <= down_rhs);

  always_comb begin
    dec_o.action  = ACT_NONE;
    dec_o.target  = '0;
    dec_o.mult_op = MULT_KEEP;
    if (high_load) begin
      if (!at_top) begin
        dec_o.action = ACT_RAISE;
        dec_o.target = up_req;
        if ((up_req == freq_max_i) || (up_req == cfg_i.big_cluster_limit)) begin
          dec_o.mult_op = MULT_LOAD;
        end
      end
    end else begin
      dec_o.mult_op = MULT_ONE;
      if ((current_freq_i != freq_min_i) && below_down) begin
        dec_o.action = ACT_LOWER;
        dec_o.target = dn_req;
      end
    end
  end

endmodule

FILE: rtl/core/load_step_frequency_governor.sv
// Top level of the load-step frequency governor: input stage, decision, result stage.
//
//   channel   direction  handshake                   payload
//   in        sink       in_valid_i / in_stall_o     cluster, load, current/min/max freq
//   out       source     out_valid_o / out_stall_i   action, target_freq, rate_multiplier
//   cfg       sink       cfg_we_i                    cfg_idx_i, cfg_wdata_i
//
// One word per cycle sustained while out is not stalled; a word passes the input register,
// then the decision logic into the result register, which drives out_valid_o.
// The per-cluster multiplier is read and written as a word leaves the input stage,
// so the following word already sees the update.
// Reset (rst_ni low, async) empties both stages, loads the register defaults and
// sets both multipliers to 1. A stall on out holds the result and backs up into
// in_stall_o only when the input stage is also full.
module load_step_frequency_governor import lsfg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // input words
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  cluster_i,
  input  logic [LOAD_W-1:0]     load_i,
  input  logic [FREQ_W-1:0]     current_freq_i,
  input  logic [FREQ_W-1:0]     freq_min_i,
  input  logic [FREQ_W-1:0]     freq_max_i,
  // result words
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            action_o,
  output logic [FREQ_W-1:0]     target_freq_o,
  output logic [MULT_W-1:0]     rate_multiplier_o
);

  lsfg_cfg_t cfg;
  lsfg_dec_t dec;

  // input stage
  logic              s1_valid_q, s1_valid_d;
  logic              s1_cluster_q;
  logic [LOAD_W-1:0] s1_load_q;
  logic [FREQ_W-1:0] s1_cur_q;
  logic [FREQ_W-1:0] s1_min_q;
  logic [FREQ_W-1:0] s1_max_q;

  // result stage
  logic              out_valid_q, out_valid_d;
  lsfg_action_e      out_action_q;
  logic [FREQ_W-1:0] out_target_q;
  logic [MULT_W-1:0] out_mult_q;

  // per-cluster rate multiplier
  logic [MULT_W-1:0] mult_q [2];
  logic [MULT_W-1:0] mult_new;

  logic in_fire;
  logic s2_ready;
  logic s1_fire;

  lsfg_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lsfg_decide u_decide (
    .cfg_i          (cfg),
    .cluster_i      (s1_cluster_q),
    .load_i         (s1_load_q),
    .current_freq_i (s1_cur_q),
    .freq_min_i     (s1_min_q),
    .freq_max_i     (s1_max_q),
    .dec_o          (dec)
  );

  // handshake
  assign s2_ready   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && s2_ready;
  assign in_stall_o = s1_valid_q && !s2_ready;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire)      s1_valid_d = 1'b1;
    else if (s1_fire) s1_valid_d = 1'b0;
  end

  assign out_valid_d = s2_ready ? s1_valid_q : out_valid_q;

  // multiplier after this word
  always_comb begin
    case (dec.mult_op)
      MULT_LOAD: mult_new = cfg.hold_factor;
      MULT_ONE:  mult_new = MULT_ONE_VAL;
      default:   mult_new = mult_q[s1_cluster_q];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mult_q[0]   <= MULT_ONE_VAL;
      mult_q[1]   <= MULT_ONE_VAL;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_fire) begin
        mult_q[s1_cluster_q] <= mult_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cluster_q <= cluster_i;
      s1_load_q    <= load_i;
      s1_cur_q     <= current_freq_i;
      s1_min_q     <= freq_min_i;
      s1_max_q     <= freq_max_i;
    end
    if (s1_fire) begin
      out_action_q <= dec.action;
      out_target_q <= dec.target;
      out_mult_q   <= mult_new;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign action_o          = out_action_q;
  assign target_freq_o     = out_target_q;
  assign rate_multiplier_o = out_mult_q;

endmodule
